FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with synchronous reset masking.
`define IEMA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define IEMA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/iema_pkg.sv
// Package of constants for the integer moving average filter.
package iema_pkg;

   // Register file addressing
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE_FACTOR = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WEIGHT_NEW   = 2'd1;

   // Register reset values
   localparam int SCALE_RESET  = 16;
   localparam int WEIGHT_RESET = 16;

endpackage

FILE: rtl/core/iema_if.sv
// Valid/ready channel interfaces for the filter's sample and result words.
interface iema_req_if #(parameter int SAMPLE_WIDTH = 16) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           restart;

   modport source (output valid, sample, restart, input ready);
   modport sink (input valid, sample, restart, output ready);
endinterface

interface iema_rsp_if #(parameter int SAMPLE_WIDTH = 16) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] smoothed;

   modport source (output valid, smoothed, input ready);
   modport sink (input valid, smoothed, output ready);
endinterface

FILE: rtl/core/integer_ema_filter.sv
// Integer exponential moving average filter with bit-serial multiply and divide.
//
// Each input word carries one signed sample and yields one smoothed word,
// y = (w*x + (s-w)*h) / s, truncated toward zero, where h is the stored history.
// The block works on one word at a time. A word that passes straight through
// (first sample, restart, or invalid configuration) gives its result in the
// cycle after it is accepted. A filtered word runs through a bit-serial
// multiplier (one weight bit per cycle), a sign-strip step and a restoring
// divider (one quotient bit per cycle), whose final step registers the result.
// A new word is accepted once the previous result has been taken. Write
// configuration only while idle.
module integer_ema_filter
   import iema_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16,
   parameter int SCALE_WIDTH  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   iema_req_if.sink                   req_chan,
   iema_rsp_if.source                 rsp_chan,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [SCALE_WIDTH-1:0]     csr_data
);

`include "assert_macros.svh"

   localparam int ACC_W = SAMPLE_WIDTH + SCALE_WIDTH + 2;
   localparam int MAG_W = SAMPLE_WIDTH + SCALE_WIDTH - 1;
   localparam int CNT_W = $clog2(MAG_W);
   localparam int DIF_W = SAMPLE_WIDTH + 1;
   localparam int REM_W = SCALE_WIDTH + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_ABS  = 2'd2;
   localparam logic [1:0] ST_DIV  = 2'd3;

   logic [1:0]              state_ff,      state_in;
   logic [SCALE_WIDTH-1:0]  scale_ff,      scale_in;
   logic [SCALE_WIDTH-1:0]  weight_ff,     weight_in;
   logic [SAMPLE_WIDTH-1:0] hist_ff,       hist_in;
   logic                    hist_valid_ff, hist_valid_in;
   logic [DIF_W-1:0]        diff_ff,       diff_in;
   logic [SCALE_WIDTH-1:0]  w_sh_ff,       w_sh_in;
   logic [SCALE_WIDTH-1:0]  s_sh_ff,       s_sh_in;
   logic [SCALE_WIDTH-1:0]  divisor_ff,    divisor_in;
   logic [ACC_W-1:0]        acc_ff,        acc_in;
   logic [MAG_W-1:0]        mag_ff,        mag_in;
   logic [SCALE_WIDTH-1:0]  rem_ff,        rem_in;
   logic                    neg_ff,        neg_in;
   logic [CNT_W-1:0]        cnt_ff,        cnt_in;
   logic                    rsp_valid_ff,  rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] rsp_data_ff,   rsp_data_in;

   logic                    req_accept;
   logic                    cfg_ok;
   logic [SAMPLE_WIDTH-1:0] sample_bits;
   logic [ACC_W-1:0]        diff_ext;
   logic [ACC_W-1:0]        hist_ext;
   logic [ACC_W-1:0]        acc_neg;
   logic [REM_W-1:0]        rem_shift;
   logic [REM_W:0]          rem_trial;
   logic                    q_bit;
   logic [MAG_W-1:0]        quot_full;
   logic [SAMPLE_WIDTH-1:0] quot;
   logic [SAMPLE_WIDTH-1:0] result;

   assign req_chan.ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_accept      = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.smoothed = rsp_data_ff;
   assign sample_bits     = req_chan.sample;

   // Qualify the current configuration
   assign cfg_ok = (scale_ff != '0) && (weight_ff != '0) && (weight_ff <= scale_ff);

   // Sign-extend multiplicands for the shift-add accumulator
   assign diff_ext = {{(ACC_W-DIF_W){diff_ff[DIF_W-1]}}, diff_ff};
   assign hist_ext = {{(ACC_W-SAMPLE_WIDTH){hist_ff[SAMPLE_WIDTH-1]}}, hist_ff};
   assign acc_neg  = ~acc_ff + ACC_W'(1);

   // One restoring divide step
   assign rem_shift = {rem_ff, mag_ff[MAG_W-1]};
   assign rem_trial = {1'b0, rem_shift} - {2'b00, divisor_ff};
   assign q_bit     = !rem_trial[REM_W];
   assign quot_full = {mag_ff[MAG_W-2:0], q_bit};
   assign quot      = quot_full[SAMPLE_WIDTH-1:0];
   assign result    = neg_ff ? (~quot + SAMPLE_WIDTH'(1)) : quot;

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      scale_in      = scale_ff;
      weight_in     = weight_ff;
      hist_in       = hist_ff;
      hist_valid_in = hist_valid_ff;
      diff_in       = diff_ff;
      w_sh_in       = w_sh_ff;
      s_sh_in       = s_sh_ff;
      divisor_in    = divisor_ff;
      acc_in        = acc_ff;
      mag_in        = mag_ff;
      rem_in        = rem_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes
      if (csr_write_en) begin
         case (csr_index)
            CSR_SCALE_FACTOR: scale_in  = csr_data;
            CSR_WEIGHT_NEW:   weight_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (!cfg_ok) begin
                  // Pass the raw sample; restart still clears history
                  rsp_data_in  = sample_bits;
                  rsp_valid_in = 1'b1;
                  if (req_chan.restart) begin
                     hist_in       = '0;
                     hist_valid_in = 1'b0;
                  end
               end else if (req_chan.restart || !hist_valid_ff) begin
                  // Start a new history
                  rsp_data_in   = sample_bits;
                  rsp_valid_in  = 1'b1;
                  hist_in       = sample_bits;
                  hist_valid_in = 1'b1;
               end else begin
                  // Launch the serial multiply: acc = w*(x-h) + s*h
                  diff_in    = {sample_bits[SAMPLE_WIDTH-1], sample_bits}
                             - {hist_ff[SAMPLE_WIDTH-1], hist_ff};
                  w_sh_in    = weight_ff;
                  s_sh_in    = scale_ff;
                  divisor_in = scale_ff;
                  acc_in     = '0;
                  cnt_in     = CNT_W'(SCALE_WIDTH - 1);
                  state_in   = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            // Advance one weight bit, MSB first
            acc_in  = {acc_ff[ACC_W-2:0], 1'b0}
                    + (w_sh_ff[SCALE_WIDTH-1] ? diff_ext : '0)
                    + (s_sh_ff[SCALE_WIDTH-1] ? hist_ext : '0);
            w_sh_in = {w_sh_ff[SCALE_WIDTH-2:0], 1'b0};
            s_sh_in = {s_sh_ff[SCALE_WIDTH-2:0], 1'b0};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_ABS;
            end
         end
         ST_ABS: begin
            // Strip the sign for the unsigned divider
            neg_in   = acc_ff[ACC_W-1];
            mag_in   = acc_ff[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_ff[MAG_W-1:0];
            rem_in   = '0;
            cnt_in   = CNT_W'(MAG_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Shift in one dividend bit, shift out one quotient bit
            rem_in = q_bit ? rem_trial[SCALE_WIDTH-1:0] : rem_shift[SCALE_WIDTH-1:0];
            mag_in = quot_full;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               rsp_data_in  = result;
               rsp_valid_in = 1'b1;
               hist_in      = result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scale_ff      <= SCALE_WIDTH'(SCALE_RESET);
         weight_ff     <= SCALE_WIDTH'(WEIGHT_RESET);
         hist_ff       <= '0;
         hist_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scale_ff      <= scale_in;
         weight_ff     <= weight_in;
         hist_ff       <= hist_in;
         hist_valid_ff <= hist_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      diff_ff     <= diff_in;
      w_sh_ff     <= w_sh_in;
      s_sh_ff     <= s_sh_in;
      divisor_ff  <= divisor_in;
      acc_ff      <= acc_in;
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   `IEMA_ASSERT(a_no_rsp_while_busy, clock, reset,
      (state_ff != ST_IDLE) |-> !rsp_valid_ff, "result pending while computing")
   `IEMA_ASSERT(a_rem_below_divisor, clock, reset,
      (state_ff == ST_DIV) |-> (rem_ff < divisor_ff), "divider remainder out of range")
   `IEMA_ASSERT(a_history_set, clock, reset,
      (req_accept && cfg_ok) |=> hist_valid_ff, "history not valid after accepted sample")
   `IEMA_ASSERT(a_launch_mul, clock, reset,
      (req_accept && cfg_ok && hist_valid_ff && !req_chan.restart) |=> (state_ff == ST_MUL),
      "filtered sample did not start multiply")

endmodule
